FILE: design/gtsn_pkg.sv
// ----------------------------------------------------------------------------
// gtsn_pkg: shared types and constants
// Separator table, pair ranges and the command passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package gtsn_pkg;

  localparam int unsigned BYTE_W = 8;

  // separator table, entry i at bit (63 - i) of each half
  localparam logic [63:0] SEP_LO =
    64'b1111111111111111111111111111111111100011111111110000000000111010;
  // entry 127 (del) is not a separator
  localparam logic [63:0] SEP_HI =
    64'b1000000000000000000000000001110110000000000000000000000000001000;

  localparam logic [BYTE_W-1:0] SPACE_CODE  = 8'h20;
  localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'd32;
  localparam logic [BYTE_W-1:0] DEL_CODE    = 8'h7f;
  localparam logic [BYTE_W-1:0] UPPER_A     = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_Z     = 8'h5a;
  localparam logic [BYTE_W-1:0] LEAD_PUNCT  = 8'ha1;
  localparam logic [BYTE_W-1:0] LEAD_FULLW  = 8'ha3;
  localparam logic [BYTE_W-1:0] LEAD_GRAPH  = 8'ha9;
  localparam logic [BYTE_W-1:0] TRAIL_MIN   = 8'ha1;
  localparam logic [BYTE_W-1:0] FULLW_MAX   = 8'hc0;
  localparam logic [BYTE_W-1:0] GRAPH_MIN   = 8'h6f;

  // result slots of one command, emitted lowest index first
  localparam int unsigned NUM_SLOTS = 4;
  localparam int unsigned SLOT_SP   = 0;
  localparam int unsigned SLOT_B0   = 1;
  localparam int unsigned SLOT_B1   = 2;
  localparam int unsigned SLOT_EOS  = 3;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [NUM_SLOTS-1:0] slots;
    logic [BYTE_W-1:0]    b0;
    logic [BYTE_W-1:0]    b1;
  } cmd_t;

  function automatic logic is_ascii_sep(input logic [BYTE_W-1:0] c);
    logic [5:0] idx;
    idx = ~c[5:0];
    if (c[7] || c == DEL_CODE) begin
      return 1'b0;
    end
    return c[6] ? SEP_HI[idx] : SEP_LO[idx];
  endfunction

  function automatic logic is_pair_sep(input logic [BYTE_W-1:0] a,
                                       input logic [BYTE_W-1:0] b);
    return (a == LEAD_PUNCT && b >= TRAIL_MIN) ||
           (a == LEAD_FULLW && b >= TRAIL_MIN && b <= FULLW_MAX) ||
           (a == LEAD_GRAPH && b >= GRAPH_MIN);
  endfunction

endpackage

`default_nettype wire

FILE: design/gtsn_front.sv
// ----------------------------------------------------------------------------
// gtsn_front: byte classifier
// Tracks lead bytes and pending spaces, turns each beat into at most one command.
// ----------------------------------------------------------------------------
`default_nettype none

module gtsn_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [gtsn_pkg::BYTE_W-1:0] in_byte,
  input  wire logic                      in_last,
  input  wire logic                      fifo_full,
  output logic                           fifo_push,
  output gtsn_pkg::cmd_t                 fifo_cmd
);

  logic [gtsn_pkg::BYTE_W-1:0] held_lead_r, held_lead_nxt;
  logic lead_waiting_r, lead_waiting_nxt;
  logic any_emitted_r, any_emitted_nxt;
  logic prev_space_r, prev_space_nxt;
  logic space_held_r, space_held_nxt;
  logic accept;
  logic [gtsn_pkg::BYTE_W-1:0] low_byte;
  gtsn_pkg::cmd_t cmd;

  assign in_tready = !fifo_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    held_lead_nxt    = held_lead_r;
    lead_waiting_nxt = lead_waiting_r;
    any_emitted_nxt  = any_emitted_r;
    prev_space_nxt   = prev_space_r;
    space_held_nxt   = space_held_r;
    cmd.slots        = '0;
    cmd.b0           = held_lead_r;
    cmd.b1           = in_byte;
    low_byte         = in_byte;
    if (in_byte >= gtsn_pkg::UPPER_A && in_byte <= gtsn_pkg::UPPER_Z) begin
      low_byte = in_byte + gtsn_pkg::CASE_OFFSET;
    end

    priority if (lead_waiting_r) begin
      lead_waiting_nxt = 1'b0;
      held_lead_nxt    = '0;
      if (gtsn_pkg::is_pair_sep(held_lead_r, in_byte)) begin
        if (any_emitted_r && !prev_space_r) begin
          space_held_nxt = 1'b1;
          prev_space_nxt = 1'b1;
        end
      end else begin
        // lead byte always goes out, trail space is held
        cmd.slots[gtsn_pkg::SLOT_SP] = space_held_r;
        cmd.slots[gtsn_pkg::SLOT_B0] = 1'b1;
        cmd.slots[gtsn_pkg::SLOT_B1] = (in_byte != gtsn_pkg::SPACE_CODE);
        space_held_nxt  = (in_byte == gtsn_pkg::SPACE_CODE);
        prev_space_nxt  = (in_byte == gtsn_pkg::SPACE_CODE);
        any_emitted_nxt = 1'b1;
      end
    end else if (in_byte[7]) begin
      held_lead_nxt    = in_byte;
      lead_waiting_nxt = 1'b1;
    end else if (gtsn_pkg::is_ascii_sep(in_byte)) begin
      if (any_emitted_r && !prev_space_r) begin
        space_held_nxt = 1'b1;
        prev_space_nxt = 1'b1;
      end
    end else begin
      cmd.b0 = low_byte;
      cmd.slots[gtsn_pkg::SLOT_SP] = space_held_r;
      cmd.slots[gtsn_pkg::SLOT_B0] = (low_byte != gtsn_pkg::SPACE_CODE);
      space_held_nxt  = (low_byte == gtsn_pkg::SPACE_CODE);
      prev_space_nxt  = (low_byte == gtsn_pkg::SPACE_CODE);
      any_emitted_nxt = 1'b1;
    end

    if (in_last) begin
      cmd.slots[gtsn_pkg::SLOT_EOS] = 1'b1;
      held_lead_nxt    = '0;
      lead_waiting_nxt = 1'b0;
      any_emitted_nxt  = 1'b0;
      prev_space_nxt   = 1'b0;
      space_held_nxt   = 1'b0;
    end
  end

  // beats that only park a lead byte leave no command
  assign fifo_push = accept && (|cmd.slots);
  assign fifo_cmd  = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_lead_r    <= '0;
      lead_waiting_r <= 1'b0;
      any_emitted_r  <= 1'b0;
      prev_space_r   <= 1'b0;
      space_held_r   <= 1'b0;
    end else if (accept) begin
      held_lead_r    <= held_lead_nxt;
      lead_waiting_r <= lead_waiting_nxt;
      any_emitted_r  <= any_emitted_nxt;
      prev_space_r   <= prev_space_nxt;
      space_held_r   <= space_held_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/gtsn_cmd_fifo.sv
// ----------------------------------------------------------------------------
// gtsn_cmd_fifo: command queue
// Small register queue between the classifier and the result emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module gtsn_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire gtsn_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output gtsn_pkg::cmd_t      head_cmd,
  output logic                not_empty
);

  gtsn_pkg::cmd_t mem_r [gtsn_pkg::FIFO_DEPTH];
  logic [gtsn_pkg::PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [gtsn_pkg::PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [gtsn_pkg::CNT_W-1:0] count_r, count_nxt;
  logic do_pop;

  assign full      = (count_r == gtsn_pkg::CNT_W'(gtsn_pkg::FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_cmd  = mem_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == gtsn_pkg::PTR_W'(gtsn_pkg::FIFO_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == gtsn_pkg::PTR_W'(gtsn_pkg::FIFO_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/gtsn_back.sv
// ----------------------------------------------------------------------------
// gtsn_back: result emitter
// Unpacks each command into single result beats behind an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gtsn_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire gtsn_pkg::cmd_t              head_cmd,
  input  wire logic                        fifo_not_empty,
  output logic                             fifo_pop,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [gtsn_pkg::BYTE_W-1:0]      out_byte,
  output logic                             out_present,
  output logic                             out_end
);

  gtsn_pkg::cmd_t cur_r, cur_nxt;
  logic [gtsn_pkg::NUM_SLOTS-1:0] pick;
  logic [gtsn_pkg::NUM_SLOTS-1:0] mask_after;
  logic load;
  logic out_vld_r, out_vld_nxt;
  logic [gtsn_pkg::BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic out_present_r, out_present_nxt;
  logic out_end_r, out_end_nxt;

  assign load = !out_vld_r || out_tready;

  always_comb begin
    pick            = '0;
    out_byte_nxt    = out_byte_r;
    out_present_nxt = out_present_r;
    out_end_nxt     = out_end_r;
    priority if (cur_r.slots[gtsn_pkg::SLOT_SP]) begin
      pick[gtsn_pkg::SLOT_SP] = 1'b1;
      out_byte_nxt    = gtsn_pkg::SPACE_CODE;
      out_present_nxt = 1'b1;
      out_end_nxt     = 1'b0;
    end else if (cur_r.slots[gtsn_pkg::SLOT_B0]) begin
      pick[gtsn_pkg::SLOT_B0] = 1'b1;
      out_byte_nxt    = cur_r.b0;
      out_present_nxt = 1'b1;
      out_end_nxt     = 1'b0;
    end else if (cur_r.slots[gtsn_pkg::SLOT_B1]) begin
      pick[gtsn_pkg::SLOT_B1] = 1'b1;
      out_byte_nxt    = cur_r.b1;
      out_present_nxt = 1'b1;
      out_end_nxt     = 1'b0;
    end else if (cur_r.slots[gtsn_pkg::SLOT_EOS]) begin
      pick[gtsn_pkg::SLOT_EOS] = 1'b1;
      out_byte_nxt    = '0;
      out_present_nxt = 1'b0;
      out_end_nxt     = 1'b1;
    end else begin
      pick = '0;
    end

    mask_after  = load ? (cur_r.slots & ~pick) : cur_r.slots;
    // refill as soon as the current command runs dry
    fifo_pop    = fifo_not_empty && (mask_after == '0);
    cur_nxt     = cur_r;
    cur_nxt.slots = mask_after;
    if (fifo_pop) begin
      cur_nxt = head_cmd;
    end
    out_vld_nxt = load ? (|cur_r.slots) : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.slots <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      cur_r.slots <= cur_nxt.slots;
      out_vld_r   <= out_vld_nxt;
    end
    cur_r.b0 <= cur_nxt.b0;
    cur_r.b1 <= cur_nxt.b1;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r    <= out_byte_nxt;
      out_present_r <= out_present_nxt;
      out_end_r     <= out_end_nxt;
    end
  end

  assign out_tvalid  = out_vld_r;
  assign out_byte    = out_byte_r;
  assign out_present = out_present_r;
  assign out_end     = out_end_r;

endmodule

`default_nettype wire

FILE: design/gbk_text_separator_normalizer.sv
// ----------------------------------------------------------------------------
// gbk_text_separator_normalizer: gbk/ascii separator normalizer
// Path: command queue, then command register cur_r, then output register.
// Throughput: one input beat per cycle while the 4-entry command queue has
// room; one result beat per cycle while out_tready is high.
// Reset: synchronous active-low rst_n clears the front state, queue and output.
// ----------------------------------------------------------------------------
`default_nettype none

module gbk_text_separator_normalizer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // last_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tuser,  // byte_present
  output logic            out_tlast   // end_of_string
);

  logic           fifo_full;
  logic           fifo_push;
  logic           fifo_pop;
  logic           fifo_not_empty;
  gtsn_pkg::cmd_t push_cmd;
  gtsn_pkg::cmd_t head_cmd;

  gtsn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .fifo_full (fifo_full),
    .fifo_push (fifo_push),
    .fifo_cmd  (push_cmd)
  );

  gtsn_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_cmd  (push_cmd),
    .full      (fifo_full),
    .pop       (fifo_pop),
    .head_cmd  (head_cmd),
    .not_empty (fifo_not_empty)
  );

  gtsn_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_cmd       (head_cmd),
    .fifo_not_empty (fifo_not_empty),
    .fifo_pop       (fifo_pop),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_byte       (out_tdata),
    .out_present    (out_tuser),
    .out_end        (out_tlast)
  );

endmodule

`default_nettype wire
